// ===== rtl/core/psxhs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psxhs_pkg
// shared types, codes and the command byte table of the pad host sequencer
// ----------------------------------------------------------------------------
package psxhs_pkg;

  localparam int unsigned POLL_BYTES_DEFAULT   = 21;
  localparam int unsigned CONFIG_BYTES_DEFAULT = 9;
  localparam int unsigned POS_W                = 5;

  localparam logic [7:0] BYTE_START     = 8'h01;
  localparam logic [7:0] BYTE_POLL      = 8'h42;
  localparam logic [7:0] BYTE_CONFIG    = 8'h43;
  localparam logic [7:0] BYTE_SET_MODE  = 8'h44;
  localparam logic [7:0] BYTE_MOTOR_MAP = 8'h4D;
  localparam logic [7:0] BYTE_PAD       = 8'h5A;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [7:0] BYTE_ONES      = 8'hFF;
  localparam logic [7:0] BYTE_ANALOG    = 8'h01;
  localparam logic [7:0] BYTE_LOCK      = 8'h03;
  localparam logic [7:0] BYTE_MOTOR2_ON = 8'h01;
  localparam logic [7:0] ID_ANALOG      = 8'h73;
  localparam logic [7:0] ID_DIGITAL     = 8'h41;
  localparam logic [7:0] STICK_CENTER   = 8'h80;
  localparam logic [15:0] DIGITAL_MASK  = 16'hFFF9;

  typedef enum logic [1:0] {
    REQ_POLL  = 2'd0,
    REQ_MODE  = 2'd1,
    REQ_MOTOR = 2'd2,
    REQ_RX    = 2'd3
  } req_type_t;

  typedef enum logic [3:0] {
    KIND_IDLE  = 4'b0001,
    KIND_POLL  = 4'b0010,
    KIND_MODE  = 4'b0100,
    KIND_MOTOR = 4'b1000
  } kind_t;

  typedef enum logic [2:0] {
    CMD_POLL  = 3'd0,
    CMD_ENTER = 3'd1,
    CMD_MODE  = 3'd2,
    CMD_MOTOR = 3'd3,
    CMD_EXIT  = 3'd4
  } cmd_t;

  typedef struct packed {
    req_type_t  req_type;
    logic [7:0] rx_byte;
    logic       analog_select;
    logic       lock_select;
    logic       small_motor_on;
    logic [7:0] large_motor_level;
    logic       first_motor_enable;
    logic       second_motor_enable;
  } req_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        frame_end;
    logic        seq_done;
    logic        report_valid;
    logic [7:0]  pad_id;
    logic [15:0] buttons;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
  } res_t;

  // command byte at a given position of the current frame
  function automatic logic [7:0] frame_byte(input kind_t kind, input logic [1:0] frame,
                                            input logic [POS_W-1:0] pos,
                                            input logic [7:0] op0, input logic [7:0] op1);
    cmd_t       cmd;
    logic [7:0] b;
    if (kind == KIND_POLL) begin
      cmd = CMD_POLL;
    end else if (frame == 2'd0) begin
      cmd = CMD_ENTER;
    end else if (frame == 2'd1) begin
      cmd = (kind == KIND_MODE) ? CMD_MODE : CMD_MOTOR;
    end else begin
      cmd = CMD_EXIT;
    end
    if (pos == POS_W'(0)) begin
      b = BYTE_START;
    end else if (pos == POS_W'(1)) begin
      case (cmd)
        CMD_POLL:  b = BYTE_POLL;
        CMD_MODE:  b = BYTE_SET_MODE;
        CMD_MOTOR: b = BYTE_MOTOR_MAP;
        default:   b = BYTE_CONFIG;
      endcase
    end else if (pos == POS_W'(2)) begin
      b = BYTE_ZERO;
    end else if (pos inside {POS_W'(3), POS_W'(4)}) begin
      if (cmd inside {CMD_POLL, CMD_MODE, CMD_MOTOR}) begin
        b = (pos == POS_W'(3)) ? op0 : op1;
      end else if (cmd == CMD_ENTER) begin
        b = (pos == POS_W'(3)) ? BYTE_START : BYTE_ZERO;
      end else begin
        b = (pos == POS_W'(3)) ? BYTE_ZERO : BYTE_PAD;
      end
    end else if (cmd == CMD_MOTOR) begin
      b = BYTE_ONES;
    end else if (cmd == CMD_EXIT) begin
      b = BYTE_PAD;
    end else begin
      b = BYTE_ZERO;
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/psx_pad_host_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psx_pad_host_sequencer_top
// host side byte sequencer for a game pad exchange
// ----------------------------------------------------------------------------
// Each request is either a sequence start (poll, set mode, motor enable) or a
// byte just received from the pad; each produces exactly one result in the
// next cycle, carrying the next byte to transmit, frame and sequence end
// marks, and at the end of a poll the decoded pad report. Throughput is one
// request per clock: the only stage is the result register, and req_ready is
// high whenever that register is empty or being drained in the same cycle.
// A poll is POLL_BYTES bytes in one frame; set mode and motor enable are
// three frames of CONFIG_BYTES bytes each. Start requests while busy and
// received bytes while idle give an all-zero result. Bytes are in protocol
// order; the serializer sends them LSB first.
module psx_pad_host_sequencer_top #(
  parameter int unsigned POLL_BYTES   = psxhs_pkg::POLL_BYTES_DEFAULT,
  parameter int unsigned CONFIG_BYTES = psxhs_pkg::CONFIG_BYTES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  psxhs_pkg::req_t req_data,
  output logic            res_valid,
  input  logic            res_ready,
  output psxhs_pkg::res_t res_data
);

  localparam int unsigned PW = psxhs_pkg::POS_W;

  // sequence state
  psxhs_pkg::kind_t kind, kind_next;
  logic [1:0]       frame, frame_next;
  logic [PW-1:0]    pos, pos_next;
  logic [7:0]       op0, op0_next;
  logic [7:0]       op1, op1_next;
  logic [7:0]       cap_id, cap_id_next;
  logic [15:0]      cap_btn, cap_btn_next;
  logic [7:0]       stick [4];
  logic [7:0]       stick_next [4];

  psxhs_pkg::res_t res_next;
  logic            accept;
  logic [PW:0]     pos_inc;
  logic [PW:0]     flen;
  logic [15:0]     btn;

  // result register empties or drains this cycle
  assign req_ready = !res_valid || res_ready;
  assign accept    = req_valid && req_ready;

  assign pos_inc = {1'b0, pos} + (PW+1)'(1);
  assign flen    = (kind == psxhs_pkg::KIND_POLL) ? (PW+1)'(POLL_BYTES)
                                                  : (PW+1)'(CONFIG_BYTES);

  always_comb begin
    kind_next    = kind;
    frame_next   = frame;
    pos_next     = pos;
    op0_next     = op0;
    op1_next     = op1;
    cap_id_next  = cap_id;
    cap_btn_next = cap_btn;
    stick_next   = stick;
    res_next     = '0;
    btn          = '0;

    if (req_data.req_type != psxhs_pkg::REQ_RX) begin
      // start request, taken only when idle
      if (kind == psxhs_pkg::KIND_IDLE) begin
        case (req_data.req_type)
          psxhs_pkg::REQ_POLL: begin
            kind_next = psxhs_pkg::KIND_POLL;
            op0_next  = req_data.small_motor_on ? psxhs_pkg::BYTE_ONES : psxhs_pkg::BYTE_ZERO;
            op1_next  = req_data.large_motor_level;
          end
          psxhs_pkg::REQ_MODE: begin
            kind_next = psxhs_pkg::KIND_MODE;
            op0_next  = req_data.analog_select ? psxhs_pkg::BYTE_ANALOG : psxhs_pkg::BYTE_ZERO;
            op1_next  = req_data.lock_select ? psxhs_pkg::BYTE_LOCK : psxhs_pkg::BYTE_ZERO;
          end
          default: begin
            kind_next = psxhs_pkg::KIND_MOTOR;
            op0_next  = req_data.first_motor_enable ? psxhs_pkg::BYTE_ZERO
                                                    : psxhs_pkg::BYTE_ONES;
            op1_next  = req_data.second_motor_enable ? psxhs_pkg::BYTE_MOTOR2_ON
                                                     : psxhs_pkg::BYTE_ONES;
          end
        endcase
        frame_next       = 2'd0;
        pos_next         = '0;
        res_next.tx_valid = 1'b1;
        res_next.tx_byte  = psxhs_pkg::BYTE_START;
      end
    end else if (kind != psxhs_pkg::KIND_IDLE) begin
      // capture the pad report while polling
      if (kind == psxhs_pkg::KIND_POLL) begin
        case (pos)
          PW'(1): cap_id_next = req_data.rx_byte;
          PW'(3): cap_btn_next[7:0] = req_data.rx_byte;
          PW'(4): cap_btn_next[15:8] = req_data.rx_byte;
          PW'(5): stick_next[0] = req_data.rx_byte;
          PW'(6): stick_next[1] = req_data.rx_byte;
          PW'(7): stick_next[2] = req_data.rx_byte;
          PW'(8): stick_next[3] = req_data.rx_byte;
          default: ;
        endcase
      end

      if (pos_inc < flen) begin
        // more bytes in this frame
        pos_next          = pos_inc[PW-1:0];
        res_next.tx_valid = 1'b1;
        res_next.tx_byte  = psxhs_pkg::frame_byte(kind, frame, pos_inc[PW-1:0], op0, op1);
      end else begin
        res_next.frame_end = 1'b1;
        if (kind != psxhs_pkg::KIND_POLL && frame < 2'd2) begin
          // next frame of a config sequence
          frame_next        = frame + 2'd1;
          pos_next          = '0;
          res_next.tx_valid = 1'b1;
          res_next.tx_byte  = psxhs_pkg::BYTE_START;
        end else begin
          res_next.seq_done = 1'b1;
          if (kind == psxhs_pkg::KIND_POLL) begin
            // decode from the values including this byte
            btn             = ~cap_btn_next;
            res_next.pad_id = cap_id_next;
            if (cap_id_next == psxhs_pkg::ID_ANALOG) begin
              res_next.report_valid = 1'b1;
              res_next.buttons      = btn;
              res_next.left_x       = stick_next[2];
              res_next.left_y       = stick_next[3];
              res_next.right_x      = stick_next[0];
              res_next.right_y      = stick_next[1];
            end else if (cap_id_next == psxhs_pkg::ID_DIGITAL) begin
              res_next.report_valid = 1'b1;
              res_next.buttons      = btn & psxhs_pkg::DIGITAL_MASK;
              res_next.left_x       = psxhs_pkg::STICK_CENTER;
              res_next.left_y       = psxhs_pkg::STICK_CENTER;
              res_next.right_x      = psxhs_pkg::STICK_CENTER;
              res_next.right_y      = psxhs_pkg::STICK_CENTER;
            end
          end
          kind_next  = psxhs_pkg::KIND_IDLE;
          frame_next = 2'd0;
          pos_next   = '0;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      kind      <= psxhs_pkg::KIND_IDLE;
      frame     <= 2'd0;
      pos       <= '0;
      op0       <= '0;
      op1       <= '0;
      cap_id    <= '0;
      cap_btn   <= '1;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        kind    <= kind_next;
        frame   <= frame_next;
        pos     <= pos_next;
        op0     <= op0_next;
        op1     <= op1_next;
        cap_id  <= cap_id_next;
        cap_btn <= cap_btn_next;
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload: stick store and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      stick    <= stick_next;
      res_data <= res_next;
    end
  end

  // a report only comes with the end of a sequence
  a_report_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.report_valid |-> res_data.seq_done)
    else $error("report without sequence end");

  // a sequence end is always a frame end
  a_done_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.seq_done |-> res_data.frame_end)
    else $error("sequence end without frame end");

  // finishing a sequence leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    accept && res_next.seq_done |=> kind == psxhs_pkg::KIND_IDLE)
    else $error("not idle after sequence end");

  // byte position stays inside the frame
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    kind != psxhs_pkg::KIND_IDLE |-> pos_inc <= flen)
    else $error("byte position past frame end");

  // config sequences have three frames only
  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    frame != 2'd3)
    else $error("frame number out of range");

endmodule
